@@ rtl/core/lms_pkg.sv @@
// Types and constants shared by the localization mode supervisor
`default_nettype none

package lms_pkg;

  // apb address width: one 32-bit register at byte address 0
  localparam int unsigned LmsAddrW = 3;
  localparam int unsigned LmsDataW = 32;

  // register word index of localizer_mode
  localparam logic [LmsAddrW-3:0] RegLocalizerMode = '0;

  // localization health states
  typedef enum logic [2:0] {
    ST_UNINIT  = 3'd0,
    ST_INIT    = 3'd1,
    ST_OPER    = 3'd2,
    ST_DEGR    = 3'd3,
    ST_NOLIDAR = 3'd4,
    ST_MANUAL  = 3'd5
  } lms_state_e;

  // event codes
  typedef enum logic [2:0] {
    EV_POSE      = 3'd0,
    EV_GOOD      = 3'd1,
    EV_POOR      = 3'd2,
    EV_UNUSABLE  = 3'd3,
    EV_LIDARFAIL = 3'd4,
    EV_SWITCHGPS = 3'd5,
    EV_TIMEOUT   = 3'd6,
    EV_GNSSTO    = 3'd7
  } lms_event_e;

  // localizer modes; codes 6 and 7 have no name and match only the to_manual test
  typedef enum logic [2:0] {
    MODE_NDT      = 3'd0,
    MODE_GNSS     = 3'd1,
    MODE_AUTO_TO  = 3'd2,
    MODE_AUTO_NTO = 3'd3,
    MODE_GNSS_NDT = 3'd4,
    MODE_GNSS_FIX = 3'd5
  } lms_mode_e;

  // outcome of one event, from the transition logic to the top
  typedef struct packed {
    logic [2:0] state_next;
    logic       has_rule;
    logic       fault_set;
  } lms_step_t;

endpackage

`default_nettype wire

@@ rtl/core/lms_cfg.sv @@
// APB register block holding the localizer mode
`default_nettype none

module lms_cfg
  import lms_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [LmsAddrW-1:0] paddr,
  input  wire logic [LmsDataW-1:0] pwdata,
  output logic      [LmsDataW-1:0] prdata,
  output logic                     pready,
  output logic      [2:0]          mode_o
);

  logic [2:0] mode_q, mode_d;
  logic       wr_en;
  logic       sel_mode;

  // address decode on word index
  assign sel_mode = (paddr[LmsAddrW-1:2] == RegLocalizerMode);
  assign wr_en    = psel && penable && pwrite && pready;

  // mode register update
  always_comb begin
    mode_d = mode_q;
    if (wr_en && sel_mode) begin
      mode_d = pwdata[2:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NDT;
    end else begin
      mode_q <= mode_d;
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (sel_mode) begin
      prdata = {{(LmsDataW-3){1'b0}}, mode_q};
    end
  end

  assign pready = 1'b1;
  assign mode_o = mode_q;

endmodule

`default_nettype wire

@@ rtl/core/lms_next.sv @@
// Transition rules of the localization supervisor
`default_nettype none

module lms_next
  import lms_pkg::*;
(
  input  wire logic [2:0] state_i,
  input  wire logic [2:0] event_i,
  input  wire logic [2:0] mode_i,
  output lms_step_t       step_o
);

  logic gnss_only;
  logic auto_mode;
  logic to_manual;

  // mode tests
  assign gnss_only = (mode_i inside {MODE_GNSS, MODE_GNSS_FIX});
  assign auto_mode = (mode_i inside {MODE_AUTO_TO, MODE_AUTO_NTO});
  // timeout without lidar fix: ndt, auto with timeout and the unnamed codes
  assign to_manual = !(mode_i inside {MODE_GNSS, MODE_AUTO_NTO, MODE_GNSS_NDT,
                                      MODE_GNSS_FIX});

  // next state per current state and event
  always_comb begin
    step_o.state_next = state_i;
    step_o.has_rule   = 1'b0;
    step_o.fault_set  = 1'b0;
    case (state_i)
      ST_UNINIT, ST_MANUAL: begin
        if (event_i == EV_POSE) begin
          step_o.has_rule   = 1'b1;
          step_o.state_next = gnss_only ? ST_NOLIDAR : ST_INIT;
        end
      end
      ST_INIT: begin
        case (event_i)
          EV_GOOD: begin
            step_o.has_rule   = 1'b1;
            step_o.state_next = ST_OPER;
          end
          EV_POOR: begin
            step_o.has_rule   = 1'b1;
            step_o.state_next = ST_DEGR;
          end
          EV_LIDARFAIL: begin
            step_o.has_rule   = 1'b1;
            step_o.state_next = (mode_i == MODE_NDT) ? ST_MANUAL : ST_NOLIDAR;
          end
          EV_TIMEOUT: begin
            step_o.has_rule   = 1'b1;
            step_o.state_next = ST_MANUAL;
          end
          default: ;
        endcase
      end
      ST_OPER: begin
        case (event_i)
          EV_POSE: begin
            step_o.has_rule   = 1'b1;
            step_o.state_next = ST_INIT;
          end
          EV_POOR: begin
            step_o.has_rule   = 1'b1;
            step_o.state_next = ST_DEGR;
          end
          EV_LIDARFAIL, EV_UNUSABLE: begin
            step_o.has_rule   = 1'b1;
            step_o.state_next = auto_mode ? ST_NOLIDAR : ST_MANUAL;
          end
          EV_SWITCHGPS: begin
            step_o.has_rule = 1'b1;
            if (mode_i == MODE_GNSS_NDT) begin
              step_o.state_next = ST_NOLIDAR;
            end
          end
          default: ;
        endcase
      end
      ST_DEGR: begin
        case (event_i)
          EV_POSE: begin
            step_o.has_rule   = 1'b1;
            step_o.state_next = ST_INIT;
          end
          EV_GOOD: begin
            step_o.has_rule   = 1'b1;
            step_o.state_next = ST_OPER;
          end
          EV_LIDARFAIL, EV_UNUSABLE: begin
            step_o.has_rule   = 1'b1;
            step_o.state_next = auto_mode ? ST_NOLIDAR : ST_MANUAL;
          end
          default: ;
        endcase
      end
      ST_NOLIDAR: begin
        case (event_i)
          EV_POSE: begin
            step_o.has_rule = 1'b1;
            if (!gnss_only) begin
              step_o.state_next = ST_INIT;
            end
          end
          EV_GOOD: begin
            step_o.has_rule = 1'b1;
            if (!gnss_only) begin
              step_o.state_next = ST_OPER;
            end
          end
          EV_TIMEOUT: begin
            step_o.has_rule = 1'b1;
            if (to_manual) begin
              step_o.state_next = ST_MANUAL;
            end
          end
          EV_GNSSTO: begin
            step_o.has_rule  = 1'b1;
            step_o.fault_set = 1'b1;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/localization_mode_supervisor_fsm.sv @@
// Localization health supervisor: input register, transition logic, result register
//
// One event item is taken per clock cycle while in_stall_o is low; each event
// waits in the input register, and its result item is loaded into the result
// register once the output is free, so items stream back to back at one per
// cycle while out_stall_i is low. The state register is updated at the
// same edge that loads the result register, so the following item sees the
// new state. A gnss timeout in the no-lidar state latches
// fatal_fault_o; after that every event returns the frozen state until reset.
// The localizer mode sits at APB byte address 0 and should be written only
// while no item is in flight.
`default_nettype none

module localization_mode_supervisor_fsm
  import lms_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // apb configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [LmsAddrW-1:0] paddr,
  input  wire logic [LmsDataW-1:0] pwdata,
  output logic      [LmsDataW-1:0] prdata,
  output logic                     pready,
  // event items
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [2:0]          event_code_i,
  // result items
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic      [2:0]          current_state_o,
  output logic      [2:0]          previous_state_o,
  output logic                     state_changed_o,
  output logic                     event_unhandled_o,
  output logic                     fatal_fault_o
);

  logic       [2:0] mode;
  lms_step_t        step;

  logic             in_vld_q, in_vld_d;
  logic       [2:0] event_q;
  lms_state_e       state_q, state_d;
  logic             fault_q, fault_d;
  logic             out_vld_q, out_vld_d;
  logic       [2:0] cur_q, prev_q;
  logic             chg_q, unh_q, fat_q;
  logic             out_free;
  logic             advance;
  logic             in_take;

  lms_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mode_o  (mode)
  );

  lms_next u_next (
    .state_i (state_q),
    .event_i (event_q),
    .mode_i  (mode),
    .step_o  (step)
  );

  // pipeline flow control
  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // next state and fault latch; a latched fault freezes everything
  always_comb begin
    state_d = state_q;
    fault_d = fault_q;
    if (advance && !fault_q) begin
      state_d = lms_state_e'(step.state_next);
      fault_d = step.fault_set;
    end
  end

  always_comb begin
    in_vld_d = in_take ? 1'b1 : (advance ? 1'b0 : in_vld_q);
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= ST_UNINIT;
      fault_q   <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      state_q   <= state_d;
      fault_q   <= fault_d;
    end
  end

  // input payload register
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      event_q <= event_code_i;
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      cur_q  <= state_d;
      prev_q <= state_q;
      chg_q  <= (state_d != state_q);
      unh_q  <= !fault_q && !step.has_rule;
      fat_q  <= fault_d;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign current_state_o   = cur_q;
  assign previous_state_o  = prev_q;
  assign state_changed_o   = chg_q;
  assign event_unhandled_o = unh_q;
  assign fatal_fault_o     = fat_q;

  // fault latch never clears outside reset
  assert property (@(posedge clk_i) disable iff (!rst_ni) fault_q |=> fault_q)
    else $error("fault latch cleared");

  // a fatal result never reports a move or a missing rule
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fatal_fault_o |-> !state_changed_o && !event_unhandled_o)
    else $error("fatal result with state change or unhandled flag");

  // state moves only when an item is processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("state moved without an item");

  // input stalls only while a result waits at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_vld_q && out_stall_i)
    else $error("input stalled without output backpressure");

endmodule

`default_nettype wire

@@ verif/tb_localization_mode_supervisor_fsm.sv @@
// Self-checking testbench for the localization mode supervisor with a built-in next-state predictor
`timescale 1ns / 100ps

module tb_localization_mode_supervisor_fsm;
  import lms_pkg::*;

  // mode codes that carry no name in the package
  localparam logic [2:0] ModeUnnamedLo = 3'd6;
  localparam logic [2:0] ModeUnnamedHi = 3'd7;

  // byte addresses of the mode register and of an unused word
  localparam logic [LmsAddrW-1:0] ModeAddr  = {RegLocalizerMode, 2'b00};
  localparam logic [LmsAddrW-1:0] SpareAddr = {~RegLocalizerMode, 2'b00};

  localparam int DrainCycles   = 4;
  localparam int SettleCycles  = 8;
  localparam int HoldCycles    = 64;
  localparam int ItemsPerPhase = 137;
  localparam int ModePhases    = 8;

  // one result item of the supervisor
  typedef struct packed {
    lms_state_e cur_st;
    lms_state_e prev_st;
    logic       changed;
    logic       unhandled;
    logic       fatal;
  } health_result_t;

  typedef enum logic [1:0] {
    ROW_EVENT,
    ROW_MODE,
    ROW_SPARE
  } row_kind_e;

  // one directed step: an event item or a register write
  typedef struct packed {
    row_kind_e      kind;
    logic [2:0]     value;
    logic           typed;
    health_result_t exp;
  } stim_row_t;

  localparam health_result_t Untyped = '{ST_UNINIT, ST_UNINIT, 1'b0, 1'b0, 1'b0};
  localparam health_result_t Frozen  = '{ST_NOLIDAR, ST_NOLIDAR, 1'b0, 1'b0, 1'b1};

  // opening sequence from reset, mode ndt first
  localparam stim_row_t OpeningRows [30] = '{
    '{ROW_EVENT, EV_GOOD,      1'b1, '{ST_UNINIT, ST_UNINIT, 1'b0, 1'b1, 1'b0}},
    '{ROW_EVENT, EV_GNSSTO,    1'b1, '{ST_UNINIT, ST_UNINIT, 1'b0, 1'b1, 1'b0}},
    '{ROW_EVENT, EV_POSE,      1'b1, '{ST_INIT, ST_UNINIT, 1'b1, 1'b0, 1'b0}},
    '{ROW_EVENT, EV_POSE,      1'b1, '{ST_INIT, ST_INIT, 1'b0, 1'b1, 1'b0}},
    '{ROW_EVENT, EV_GOOD,      1'b1, '{ST_OPER, ST_INIT, 1'b1, 1'b0, 1'b0}},
    '{ROW_EVENT, EV_SWITCHGPS, 1'b0, Untyped},
    '{ROW_EVENT, EV_TIMEOUT,   1'b0, Untyped},
    '{ROW_EVENT, EV_UNUSABLE,  1'b0, Untyped},
    '{ROW_EVENT, EV_POSE,      1'b0, Untyped},
    '{ROW_EVENT, EV_LIDARFAIL, 1'b0, Untyped},
    '{ROW_EVENT, EV_POSE,      1'b0, Untyped},
    '{ROW_EVENT, EV_TIMEOUT,   1'b0, Untyped},
    '{ROW_MODE,  MODE_GNSS_NDT, 1'b0, Untyped},
    '{ROW_EVENT, EV_POSE,      1'b0, Untyped},
    '{ROW_EVENT, EV_POOR,      1'b0, Untyped},
    '{ROW_EVENT, EV_LIDARFAIL, 1'b0, Untyped},
    '{ROW_EVENT, EV_POSE,      1'b0, Untyped},
    '{ROW_EVENT, EV_GOOD,      1'b0, Untyped},
    '{ROW_EVENT, EV_SWITCHGPS, 1'b0, Untyped},
    '{ROW_EVENT, EV_TIMEOUT,   1'b0, Untyped},
    '{ROW_EVENT, EV_SWITCHGPS, 1'b0, Untyped},
    '{ROW_MODE,  ModeUnnamedHi, 1'b0, Untyped},
    '{ROW_EVENT, EV_TIMEOUT,   1'b0, Untyped},
    '{ROW_MODE,  MODE_GNSS_FIX, 1'b0, Untyped},
    '{ROW_EVENT, EV_POSE,      1'b0, Untyped},
    '{ROW_EVENT, EV_GOOD,      1'b0, Untyped},
    '{ROW_EVENT, EV_POSE,      1'b0, Untyped},
    '{ROW_MODE,  MODE_AUTO_TO, 1'b0, Untyped},
    '{ROW_SPARE, MODE_GNSS,    1'b0, Untyped},
    '{ROW_EVENT, EV_GOOD,      1'b0, Untyped}
  };

  // closing sequence: latch the fatal fault, then everything stays frozen
  localparam stim_row_t ClosingRows [13] = '{
    '{ROW_MODE,  MODE_AUTO_TO, 1'b0, Untyped},
    '{ROW_EVENT, EV_POSE,      1'b0, Untyped},
    '{ROW_EVENT, EV_LIDARFAIL, 1'b1, '{ST_NOLIDAR, ST_INIT, 1'b1, 1'b0, 1'b0}},
    '{ROW_EVENT, EV_GNSSTO,    1'b1, Frozen},
    '{ROW_EVENT, EV_POSE,      1'b1, Frozen},
    '{ROW_MODE,  MODE_GNSS,    1'b0, Untyped},
    '{ROW_EVENT, EV_GOOD,      1'b1, Frozen},
    '{ROW_EVENT, EV_POOR,      1'b1, Frozen},
    '{ROW_EVENT, EV_UNUSABLE,  1'b1, Frozen},
    '{ROW_EVENT, EV_LIDARFAIL, 1'b1, Frozen},
    '{ROW_EVENT, EV_SWITCHGPS, 1'b1, Frozen},
    '{ROW_EVENT, EV_TIMEOUT,   1'b1, Frozen},
    '{ROW_EVENT, EV_GNSSTO,    1'b1, Frozen}
  };

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [LmsAddrW-1:0] paddr        = '0;
  logic [LmsDataW-1:0] pwdata       = '0;
  logic [LmsDataW-1:0] prdata;
  logic                pready;
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic [2:0]          event_code_i = '0;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic [2:0]          current_state_o;
  logic [2:0]          previous_state_o;
  logic                state_changed_o;
  logic                event_unhandled_o;
  logic                fatal_fault_o;

  // predictor state, advanced when an item is put on the bus
  lms_state_e     plan_st    = ST_UNINIT;
  logic           plan_fault = 1'b0;
  logic [2:0]     mode_reg   = MODE_NDT;
  health_result_t health_q[$];

  int send_idle_pct = 19;
  int recv_idle_pct = 83;
  int hold_req      = 0;
  int hold_ack      = 0;
  int hold_left     = 0;

  int errors        = 0;
  int items_sent    = 0;
  int reg_writes    = 0;
  int results_seen  = 0;
  int changes_seen  = 0;
  int no_rule_seen  = 0;
  health_result_t want;

  localization_mode_supervisor_fsm uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .event_code_i     (event_code_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .current_state_o  (current_state_o),
    .previous_state_o (previous_state_o),
    .state_changed_o  (state_changed_o),
    .event_unhandled_o(event_unhandled_o),
    .fatal_fault_o    (fatal_fault_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // next health state for one event
  function automatic health_result_t supervise(input lms_state_e st, input logic fault,
                                               input logic [2:0] mode, input lms_event_e ev);
    health_result_t res;
    lms_state_e     nx;
    logic           has_rule;
    logic           gnss_only;
    logic           auto_sel;
    logic           fault_nx;
    gnss_only = (mode == MODE_GNSS) || (mode == MODE_GNSS_FIX);
    auto_sel  = (mode == MODE_AUTO_TO) || (mode == MODE_AUTO_NTO);
    nx        = st;
    has_rule  = 1'b1;
    fault_nx  = fault;
    if (!fault) begin
      case (st)
        ST_UNINIT, ST_MANUAL: begin
          if (ev == EV_POSE) nx = gnss_only ? ST_NOLIDAR : ST_INIT;
          else has_rule = 1'b0;
        end
        ST_INIT: begin
          case (ev)
            EV_GOOD:      nx = ST_OPER;
            EV_POOR:      nx = ST_DEGR;
            EV_LIDARFAIL: nx = (mode == MODE_NDT) ? ST_MANUAL : ST_NOLIDAR;
            EV_TIMEOUT:   nx = ST_MANUAL;
            default:      has_rule = 1'b0;
          endcase
        end
        ST_OPER: begin
          case (ev)
            EV_POSE:                  nx = ST_INIT;
            EV_POOR:                  nx = ST_DEGR;
            EV_LIDARFAIL, EV_UNUSABLE: nx = auto_sel ? ST_NOLIDAR : ST_MANUAL;
            EV_SWITCHGPS: begin
              if (mode == MODE_GNSS_NDT) nx = ST_NOLIDAR;
            end
            default:                  has_rule = 1'b0;
          endcase
        end
        ST_DEGR: begin
          case (ev)
            EV_POSE:                  nx = ST_INIT;
            EV_GOOD:                  nx = ST_OPER;
            EV_LIDARFAIL, EV_UNUSABLE: nx = auto_sel ? ST_NOLIDAR : ST_MANUAL;
            default:                  has_rule = 1'b0;
          endcase
        end
        ST_NOLIDAR: begin
          case (ev)
            EV_POSE: begin
              if (!gnss_only) nx = ST_INIT;
            end
            EV_GOOD: begin
              if (!gnss_only) nx = ST_OPER;
            end
            EV_TIMEOUT: begin
              // unnamed mode codes count with the timeout modes here
              if (mode == MODE_NDT || mode == MODE_AUTO_TO ||
                  mode == ModeUnnamedLo || mode == ModeUnnamedHi) nx = ST_MANUAL;
            end
            EV_GNSSTO: fault_nx = 1'b1;
            default:   has_rule = 1'b0;
          endcase
        end
        default: has_rule = 1'b0;
      endcase
    end
    res.cur_st    = nx;
    res.prev_st   = st;
    res.changed   = (nx != st);
    res.unhandled = !has_rule;
    res.fatal     = fault_nx;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [2:0] exp_v, input logic [2:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // offer one event item and wait for it to be taken
  task automatic send_event(input lms_event_e ev, input logic typed, input health_result_t exp);
    health_result_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    pred       = supervise(plan_st, plan_fault, mode_reg, ev);
    plan_st    = pred.cur_st;
    plan_fault = pred.fatal;
    health_q.push_back(typed ? exp : pred);
    in_valid_i   <= 1'b1;
    event_code_i <= ev;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // register write once the block has drained, then read the mode back
  task automatic write_reg(input logic [LmsAddrW-1:0] addr, input logic [2:0] value);
    logic [LmsDataW-1:0] data;
    data      = $urandom;
    data[2:0] = value;
    in_valid_i <= 1'b0;
    while (health_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ModeAddr) mode_reg = value;
    reg_writes++;
    // readback
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ModeAddr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("localizer_mode", mode_reg, prdata[2:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_row(input stim_row_t row);
    case (row.kind)
      ROW_EVENT: send_event(lms_event_e'(row.value), row.typed, row.exp);
      ROW_MODE:  write_reg(ModeAddr, row.value);
      default:   write_reg(SpareAddr, row.value);
    endcase
  endtask

  // result side stalls, with one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      out_stall_i <= 1'b1;
      hold_ack    <= hold_req;
      hold_left   <= HoldCycles;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (health_q.size() == 0) begin
        $error("result item with no event outstanding");
        errors++;
      end else begin
        want = health_q.pop_front();
        check_field("current_state", want.cur_st, current_state_o);
        check_field("previous_state", want.prev_st, previous_state_o);
        check_field("state_changed", want.changed, state_changed_o);
        check_field("event_unhandled", want.unhandled, event_unhandled_o);
        check_field("fatal_fault", want.fatal, fatal_fault_o);
        results_seen++;
        if (want.changed) changes_seen++;
        if (want.unhandled) no_rule_seen++;
      end
    end
  end

  // stimulus
  initial begin
    lms_event_e ev;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (OpeningRows[i]) apply_row(OpeningRows[i]);

    // random events, one phase per mode code
    for (int p = 0; p < ModePhases; p++) begin
      if (p < 3) begin
        send_idle_pct = 19;
        recv_idle_pct <= 83;
      end else if (p < 6) begin
        send_idle_pct = 83;
        recv_idle_pct <= 19;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      write_reg(ModeAddr, p[2:0]);
      if (p % 3 == 1) write_reg(SpareAddr, 3'($urandom));
      if (p == 6) hold_req <= hold_req + 1;
      repeat (ItemsPerPhase) begin
        ev = lms_event_e'($urandom_range(0, 7));
        // keep the fatal latch for the closing sequence
        if (plan_st == ST_NOLIDAR && ev == EV_GNSSTO) ev = lms_event_e'($urandom_range(0, 6));
        send_event(ev, 1'b0, Untyped);
      end
    end

    foreach (ClosingRows[i]) apply_row(ClosingRows[i]);

    in_valid_i <= 1'b0;
    while (health_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("ran %0d event items across all eight mode codes with %0d register writes",
             items_sent, reg_writes);
    $display("checked %0d results: %0d state moves, %0d events without a rule, fault latched",
             results_seen, changes_seen, no_rule_seen);
    if (errors == 0) begin
      $display("tb_localization_mode_supervisor_fsm passed");
    end else begin
      $display("tb_localization_mode_supervisor_fsm failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("timeout waiting for the supervisor");
    $display("tb_localization_mode_supervisor_fsm failed");
    $finish;
  end

endmodule

@@ localization_mode_supervisor_fsm.f @@
rtl/core/lms_pkg.sv
rtl/core/lms_cfg.sv
rtl/core/lms_next.sv
rtl/core/localization_mode_supervisor_fsm.sv
verif/tb_localization_mode_supervisor_fsm.sv
